// ----- src/tms_pkg.sv -----
package tms_pkg;

   // Tape and rule symbols
   localparam logic [7:0] SYM_DOLLAR = 8'd36;
   localparam logic [7:0] SYM_BLANK  = 8'd32;
   localparam logic [7:0] SYM_LEFT   = 8'd76;
   localparam logic [7:0] SYM_RIGHT  = 8'd82;
   localparam logic [7:0] SYM_NONE   = 8'd78;

   // Item operation codes
   localparam logic [1:0] OP_LOAD_RULE  = 2'd0;
   localparam logic [1:0] OP_WRITE_TAPE = 2'd1;
   localparam logic [1:0] OP_STEP       = 2'd2;
   localparam logic [1:0] OP_READ_TAPE  = 2'd3;

   // Head move codes
   localparam logic [1:0] MOVE_NONE  = 2'd0;
   localparam logic [1:0] MOVE_LEFT  = 2'd1;
   localparam logic [1:0] MOVE_RIGHT = 2'd2;

   // Configuration register indexes
   localparam logic [1:0] CSR_COLUMN_COUNT = 2'd0;
   localparam logic [1:0] CSR_HEAD_START   = 2'd1;
   localparam logic [1:0] CSR_TAPE_LENGTH  = 2'd2;

   // Configuration reset values
   localparam logic [4:0]  RST_COLUMN_COUNT = 5'd16;
   localparam logic [12:0] RST_HEAD_START   = 13'd4096;
   localparam logic [13:0] RST_TAPE_LENGTH  = 14'd8192;
   localparam logic [3:0]  RST_ROW          = 4'd1;

   // One rule table entry
   typedef struct packed {
      logic [1:0] move;
      logic [3:0] next_row;
      logic [7:0] symbol;
   } rule_entry_type;

   localparam rule_entry_type RULE_BLANK = '{move: MOVE_NONE, next_row: 4'd0,
                                             symbol: SYM_BLANK};

   // Rule table write request
   typedef struct packed {
      logic           we;
      logic [3:0]     row;
      logic [3:0]     col;
      rule_entry_type rule;
   } rule_write_type;

   // Column scan request
   typedef struct packed {
      logic       start;
      logic [3:0] row;
      logic [7:0] ch;
      logic [4:0] cols;
   } scan_ctrl_type;

   // Column scan result
   typedef struct packed {
      logic           done;
      logic           hit;
      rule_entry_type rule;
   } scan_status_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_SCAN,
      ST_APPLY,
      ST_RESP
   } state_type;

endpackage

// ----- src/tms_rule_scan.sv -----
module tms_rule_scan
   import tms_pkg::*;
#(
   parameter int NUM_ROWS    = 16,
   parameter int NUM_COLUMNS = 16
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          clear_we,
   input  logic [$clog2(NUM_ROWS * NUM_COLUMNS) - 1:0]   clear_addr,
   input  rule_write_type                                wr,
   input  scan_ctrl_type                                 ctrl,
   output scan_status_type                               status
);

   localparam int RULE_DEPTH = NUM_ROWS * NUM_COLUMNS;
   localparam int RULE_AW    = $clog2(RULE_DEPTH);

   rule_entry_type rule_mem [RULE_DEPTH];

   logic               busy_ff, busy_in;
   logic [4:0]         col_ff, col_in;
   logic               chk_vld_ff, chk_vld_in;
   logic [7:0]         hdr_q_ff;
   rule_entry_type     rule_q_ff;

   logic               row_ok;
   logic [3:0]         row_sel;
   logic               more_cols;
   logic               hit;
   logic               done;
   logic               issue;
   logic               wr_ok;
   logic [RULE_AW-1:0] hdr_addr;
   logic [RULE_AW-1:0] rule_addr;
   logic [RULE_AW-1:0] wr_addr;

   // Decode the scan step: check the entry read last cycle, issue the next column
   always_comb begin
      row_ok    = 32'(ctrl.row) < NUM_ROWS;
      row_sel   = row_ok ? ctrl.row : 4'd0;
      more_cols = col_ff < ctrl.cols;
      hit       = chk_vld_ff && (hdr_q_ff == ctrl.ch) && (rule_q_ff.symbol != SYM_BLANK)
                  && row_ok;
      done      = busy_ff && (hit || (!more_cols && !chk_vld_ff));
      issue     = busy_ff && more_cols && !hit;
      hdr_addr  = RULE_AW'(col_ff);
      rule_addr = RULE_AW'(row_sel) * RULE_AW'(NUM_COLUMNS) + RULE_AW'(col_ff);
      wr_ok     = wr.we && (32'(wr.row) < NUM_ROWS) && (32'(wr.col) < NUM_COLUMNS);
      wr_addr   = RULE_AW'(wr.row) * RULE_AW'(NUM_COLUMNS) + RULE_AW'(wr.col);

      busy_in    = ctrl.start ? 1'b1 : (done ? 1'b0 : busy_ff);
      col_in     = ctrl.start ? 5'd1 : (issue ? col_ff + 5'd1 : col_ff);
      chk_vld_in = issue;

      status.done = done;
      status.hit  = hit;
      status.rule = rule_q_ff;
   end

   // Advance the scan counters
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         col_ff     <= 5'd1;
         chk_vld_ff <= 1'b0;
      end else begin
         busy_ff    <= busy_in;
         col_ff     <= col_in;
         chk_vld_ff <= chk_vld_in;
      end
   end

   // Write the rule table: clearing pass first, then rule loads
   always_ff @(posedge clock) begin
      if (clear_we) begin
         rule_mem[clear_addr] <= RULE_BLANK;
      end else if (wr_ok) begin
         rule_mem[wr_addr] <= wr.rule;
      end
   end

   // Read header symbol and current row rule for one column
   always_ff @(posedge clock) begin
      if (issue) begin
         hdr_q_ff  <= rule_mem[hdr_addr].symbol;
         rule_q_ff <= rule_mem[rule_addr];
      end
   end

endmodule

// ----- src/turing_machine_step_engine.sv -----
// Single-tape Turing machine step engine. Each item loads a rule entry, writes or
// reads a tape cell, or runs one machine step, and returns one result item. After
// reset the block sweeps the tape to '$' and the rule table to blank, with req_ready
// low; configuration writes are taken throughout. Items are handled one at a time.
// A step reads one rule table entry per header column through the shared compare
// stage, plus the tape cell under the head, and stops early when a rule fires.
// A step on a halted machine does nothing; a step with the head off the tape halts
// the machine.
// Writing head_start restarts the machine: head to head_start, row 1, halt cleared.
module turing_machine_step_engine
   import tms_pkg::*;
#(
   parameter int NUM_ROWS    = 16,
   parameter int NUM_COLUMNS = 16,
   parameter int TAPE_DEPTH  = 8192
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [3:0]  req_row_index,
   input  logic [3:0]  req_column_index,
   input  logic [7:0]  req_rule_symbol,
   input  logic [3:0]  req_rule_next_row,
   input  logic [1:0]  req_rule_move,
   input  logic [12:0] req_tape_address,
   input  logic [7:0]  req_tape_value,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_cell_value,
   output logic [13:0] rsp_head_position,
   output logic [3:0]  rsp_current_row,
   output logic        rsp_rule_fired,
   output logic        rsp_halted,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [13:0] csr_wdata
);

   localparam int RULE_DEPTH = NUM_ROWS * NUM_COLUMNS;
   localparam int RULE_AW    = $clog2(RULE_DEPTH);
   localparam int TAPE_AW    = $clog2(TAPE_DEPTH);
   localparam int CLR_DEPTH  = (TAPE_DEPTH > RULE_DEPTH) ? TAPE_DEPTH : RULE_DEPTH;
   localparam int CLR_W      = $clog2(CLR_DEPTH);
   localparam int DEPTH_W    = $clog2(TAPE_DEPTH + 1);
   localparam int CMP_W      = (DEPTH_W > 14) ? DEPTH_W : 14;

   state_type       state_ff, state_in;
   logic [CLR_W-1:0] clr_ff, clr_in;

   // Configuration and machine registers
   logic [4:0]  column_count_ff;
   logic [13:0] tape_length_ff;
   logic [13:0] head_ff, head_in;
   logic [3:0]  row_ff, row_in;
   logic        halt_ff, halt_in;

   // Result registers
   logic [7:0]  cell_ff, cell_in;
   logic        fired_ff, fired_in;

   // Captured item
   logic [1:0]  op_ff;
   logic [3:0]  row_idx_ff;
   logic [3:0]  col_idx_ff;
   logic [7:0]  sym_ff;
   logic [3:0]  nxt_ff;
   logic [1:0]  mv_ff;
   logic [12:0] addr_ff;
   logic [7:0]  val_ff;

   // Rule fired by the scan
   rule_entry_type rule_ff;

   // Tape memory
   logic [7:0]         tape_mem [TAPE_DEPTH];
   logic [7:0]         tape_rd_ff;
   logic               tape_we;
   logic [TAPE_AW-1:0] tape_wa;
   logic [7:0]         tape_wd;
   logic               tape_re;
   logic [TAPE_AW-1:0] tape_ra;

   // Rule table side
   logic               rule_clear_we;
   rule_write_type     rule_wr;
   scan_ctrl_type      scan_ctrl;
   scan_status_type    scan_status;

   logic               req_accept;
   logic               csr_accept;
   logic [CMP_W-1:0]   limit;
   logic               head_bad;
   logic               addr_ok;
   logic [13:0]        head_moved;
   logic               halt_dollar;
   logic [4:0]         cols_eff;

   assign req_ready  = (state_ff == ST_IDLE);
   assign rsp_valid  = (state_ff == ST_RESP);
   assign csr_ready  = 1'b1;
   assign req_accept = req_valid && req_ready;
   assign csr_accept = csr_valid && csr_ready;

   assign rsp_cell_value    = cell_ff;
   assign rsp_head_position = head_ff;
   assign rsp_current_row   = row_ff;
   assign rsp_rule_fired    = fired_ff;
   assign rsp_halted        = halt_ff;

   // Bound the tape and the column scan
   always_comb begin
      limit    = (32'(tape_length_ff) > TAPE_DEPTH) ? CMP_W'(TAPE_DEPTH)
                                                    : CMP_W'(tape_length_ff);
      cols_eff = (32'(column_count_ff) > NUM_COLUMNS) ? 5'(NUM_COLUMNS) : column_count_ff;
      head_bad = (head_ff == 14'd0) || (CMP_W'(head_ff) >= limit);
      addr_ok  = 32'(addr_ff) < TAPE_DEPTH;
   end

   // Compute the head move and halt conditions for a fired rule
   always_comb begin
      case (rule_ff.move)
         MOVE_LEFT:  head_moved = head_ff - 14'd1;
         MOVE_RIGHT: head_moved = head_ff + 14'd1;
         default:    head_moved = head_ff;
      endcase
      halt_dollar = (tape_rd_ff == SYM_DOLLAR) && (rule_ff.symbol == SYM_DOLLAR)
                    && (rule_ff.next_row == row_ff)
                    && (rule_ff.move != MOVE_LEFT) && (rule_ff.move != MOVE_RIGHT);
   end

   // Sequence one item
   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      head_in   = head_ff;
      row_in    = row_ff;
      halt_in   = halt_ff;
      cell_in   = cell_ff;
      fired_in  = fired_ff;
      tape_we   = 1'b0;
      tape_wa   = TAPE_AW'(addr_ff);
      tape_wd   = val_ff;
      tape_re   = 1'b0;
      tape_ra   = TAPE_AW'(addr_ff);
      rule_clear_we = 1'b0;
      rule_wr.we    = 1'b0;
      rule_wr.row   = row_idx_ff;
      rule_wr.col   = col_idx_ff;
      rule_wr.rule  = '{move: mv_ff, next_row: nxt_ff, symbol: sym_ff};
      scan_ctrl.start = 1'b0;
      scan_ctrl.row   = row_ff;
      scan_ctrl.ch    = tape_rd_ff;
      scan_ctrl.cols  = cols_eff;

      case (state_ff)
         ST_CLEAR: begin
            tape_we       = 32'(clr_ff) < TAPE_DEPTH;
            tape_wa       = clr_ff[TAPE_AW-1:0];
            tape_wd       = SYM_DOLLAR;
            rule_clear_we = 32'(clr_ff) < RULE_DEPTH;
            if (32'(clr_ff) == CLR_DEPTH - 1) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + CLR_W'(1);
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cell_in  = 8'd0;
            fired_in = 1'b0;
            state_in = ST_RESP;
            case (op_ff)
               OP_LOAD_RULE: begin
                  rule_wr.we = 1'b1;
               end
               OP_WRITE_TAPE: begin
                  tape_we = addr_ok;
               end
               OP_READ_TAPE: begin
                  if (addr_ok) begin
                     tape_re  = 1'b1;
                     state_in = ST_READ;
                  end else begin
                     cell_in = SYM_DOLLAR;
                  end
               end
               default: begin
                  // Step: skip when halted, halt when the head is off the tape
                  if (!halt_ff) begin
                     if (head_bad) begin
                        halt_in = 1'b1;
                     end else begin
                        tape_re         = 1'b1;
                        tape_ra         = TAPE_AW'(head_ff);
                        scan_ctrl.start = 1'b1;
                        state_in        = ST_SCAN;
                     end
                  end
               end
            endcase
         end
         ST_READ: begin
            cell_in  = tape_rd_ff;
            state_in = ST_RESP;
         end
         ST_SCAN: begin
            if (scan_status.done) begin
               state_in = scan_status.hit ? ST_APPLY : ST_RESP;
            end
         end
         ST_APPLY: begin
            tape_we  = 1'b1;
            tape_wa  = TAPE_AW'(head_ff);
            tape_wd  = rule_ff.symbol;
            head_in  = head_moved;
            row_in   = (rule_ff.next_row != 4'd0) ? rule_ff.next_row : RST_ROW;
            halt_in  = halt_dollar || (head_moved == 14'd0) || (CMP_W'(head_moved) >= limit);
            cell_in  = rule_ff.symbol;
            fired_in = 1'b1;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Restart the machine on a head_start write
      if (csr_accept && (csr_index == CSR_HEAD_START)) begin
         head_in = {1'b0, csr_wdata[12:0]};
         row_in  = RST_ROW;
         halt_in = 1'b0;
      end
   end

   // Hold sequencer and machine state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         head_ff  <= {1'b0, RST_HEAD_START};
         row_ff   <= RST_ROW;
         halt_ff  <= 1'b0;
         cell_ff  <= 8'd0;
         fired_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         head_ff  <= head_in;
         row_ff   <= row_in;
         halt_ff  <= halt_in;
         cell_ff  <= cell_in;
         fired_ff <= fired_in;
      end
   end

   // Take configuration writes; head_start goes straight to the head, unknown indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= RST_COLUMN_COUNT;
         tape_length_ff  <= RST_TAPE_LENGTH;
      end else if (csr_accept) begin
         case (csr_index)
            CSR_COLUMN_COUNT: column_count_ff <= csr_wdata[4:0];
            CSR_TAPE_LENGTH:  tape_length_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Capture the accepted item
   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff      <= req_op;
         row_idx_ff <= req_row_index;
         col_idx_ff <= req_column_index;
         sym_ff     <= req_rule_symbol;
         nxt_ff     <= req_rule_next_row;
         mv_ff      <= req_rule_move;
         addr_ff    <= req_tape_address;
         val_ff     <= req_tape_value;
      end
   end

   // Latch the rule that fired
   always_ff @(posedge clock) begin
      if ((state_ff == ST_SCAN) && scan_status.done) begin
         rule_ff <= scan_status.rule;
      end
   end

   // Write and read the tape
   always_ff @(posedge clock) begin
      if (tape_we) begin
         tape_mem[tape_wa] <= tape_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (tape_re) begin
         tape_rd_ff <= tape_mem[tape_ra];
      end
   end

   tms_rule_scan #(
      .NUM_ROWS    (NUM_ROWS),
      .NUM_COLUMNS (NUM_COLUMNS)
   ) u_rule_scan (
      .clock      (clock),
      .reset      (reset),
      .clear_we   (rule_clear_we),
      .clear_addr (clr_ff[RULE_AW-1:0]),
      .wr         (rule_wr),
      .ctrl       (scan_ctrl),
      .status     (scan_status)
   );

endmodule
